// ===== rtl/core/cta_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cta_pkg
// Shared widths, codes and calendar helpers for the calendar time advance
// block.
// ============================================================================
package cta_pkg;

    // Field widths of one time transaction
    localparam int SEC_BITS   = 6;
    localparam int MIN_BITS   = 6;
    localparam int HOUR_BITS  = 5;
    localparam int DAY_BITS   = 5;
    localparam int MON_BITS   = 4;
    localparam int YEAR_BITS  = 10;
    localparam int ERR_BITS   = 2;

    // Configuration register widths
    localparam int COUNT_BITS    = 12;
    localparam int UNIT_BITS     = 3;
    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = (COUNT_BITS > UNIT_BITS) ? COUNT_BITS : UNIT_BITS;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_BITS-1:0] REG_STEP_COUNT = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_STEP_UNIT  = 1'b1;

    // Step units
    localparam logic [UNIT_BITS-1:0] UNIT_SECONDS = 3'd0;
    localparam logic [UNIT_BITS-1:0] UNIT_MINUTES = 3'd1;
    localparam logic [UNIT_BITS-1:0] UNIT_HOURS   = 3'd2;
    localparam logic [UNIT_BITS-1:0] UNIT_DAYS    = 3'd3;
    localparam logic [UNIT_BITS-1:0] UNIT_WEEKS   = 3'd4;
    localparam logic [UNIT_BITS-1:0] UNIT_MONTHS  = 3'd5;
    localparam logic [UNIT_BITS-1:0] UNIT_YEARS   = 3'd6;

    // Error codes
    localparam logic [ERR_BITS-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_BITS-1:0] ERR_UNIT     = 2'd1;
    localparam logic [ERR_BITS-1:0] ERR_OVERFLOW = 2'd2;

    // Working width: holds a full week step plus the input day and carries
    localparam int WORK_BITS =
        ((COUNT_BITS > YEAR_BITS) ? COUNT_BITS : YEAR_BITS) + 4;

    localparam int DAYS_PER_WEEK = 7;
    localparam int ADD_CNT_BITS  = 3;

    // Packed stream widths, rounded up to whole bytes
    localparam int IN_FIELD_BITS  =
        SEC_BITS + MIN_BITS + HOUR_BITS + DAY_BITS + MON_BITS + YEAR_BITS;
    localparam int OUT_FIELD_BITS = IN_FIELD_BITS + ERR_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Calendar constants at working width
    localparam logic [WORK_BITS-1:0] SEC_PER_MIN   = WORK_BITS'(60);
    localparam logic [WORK_BITS-1:0] MIN_PER_HOUR  = WORK_BITS'(60);
    localparam logic [WORK_BITS-1:0] HOUR_PER_DAY  = WORK_BITS'(24);
    localparam logic [WORK_BITS-1:0] MON_PER_YEAR  = WORK_BITS'(12);
    localparam logic [WORK_BITS-1:0] YEAR_BASE     = WORK_BITS'(1900);
    localparam logic [WORK_BITS-1:0] LEAP_CYCLE    = WORK_BITS'(400);
    localparam logic [WORK_BITS-1:0] YEAR_MAX      = WORK_BITS'((1 << YEAR_BITS) - 1);
    localparam logic [WORK_BITS-1:0] LAST_MONTH    = WORK_BITS'(11);
    localparam logic [WORK_BITS-1:0] LAST_CYC_YEAR = WORK_BITS'(399);

    // Gregorian rule on a year already reduced modulo 400
    function automatic logic is_leap(input logic [WORK_BITS-1:0] ymod);
        logic century;
        century = (ymod == WORK_BITS'(100)) || (ymod == WORK_BITS'(200)) ||
                  (ymod == WORK_BITS'(300));
        return (ymod[1:0] == 2'b00) && !century;
    endfunction

    // Length of a month (zero is January)
    function automatic logic [DAY_BITS-1:0] month_days(
        input logic [WORK_BITS-1:0] mon,
        input logic                 leap
    );
        logic [DAY_BITS-1:0] days;
        days = DAY_BITS'(31);
        if (mon == WORK_BITS'(1))
            days = leap ? DAY_BITS'(29) : DAY_BITS'(28);
        else if ((mon == WORK_BITS'(3)) || (mon == WORK_BITS'(5)) ||
                 (mon == WORK_BITS'(8)) || (mon == WORK_BITS'(10)))
            days = DAY_BITS'(30);
        return days;
    endfunction

endpackage

// ===== rtl/core/calendar_time_advance_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// calendar_time_advance_top
// Adds a configured step to a Gregorian broken-down time and normalizes it
// with one shared add/subtract unit under a small sequencer.
// ============================================================================
//
//  Channel   Direction  Handshake                  Contents
//  s_axis    in         s_axis_tvalid/tready       start time
//  m_axis    out        m_axis_tvalid/tready       advanced time, error code
//  cfg       in         cfg_wr_en (no wait)        step_count, step_unit
//
//  A transaction is accepted, the step is added (seven passes for weeks, none
//  for an invalid unit), carries are taken out of seconds, minutes, hours and
//  months one at a time, the year base is added, 400 years are removed at a
//  time for the leap test, whole months are walked in the day loop, and the
//  result is handed off. For large day and week steps the day loop over the
//  shared unit takes the longest. Reset clears the sequencer and the output
//  valid flag. A new start time is taken while a finished result waits on
//  m_axis.
//
module calendar_time_advance_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [cta_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [cta_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    // Start time in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // in_second, in_minute, in_hour, in_day, in_month, in_year, zero fill
    input  logic [cta_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
    // Advanced time out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_second, out_minute, out_hour, out_day, out_month, out_year,
    // error_code, zero fill
    output logic [cta_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata
);
    import cta_pkg::*;

    // Field offsets in the packed stream data
    localparam int SEC_LO  = 0;
    localparam int MIN_LO  = SEC_LO + SEC_BITS;
    localparam int HOUR_LO = MIN_LO + MIN_BITS;
    localparam int DAY_LO  = HOUR_LO + HOUR_BITS;
    localparam int MON_LO  = DAY_LO + DAY_BITS;
    localparam int YEAR_LO = MON_LO + MON_BITS;

    // Sequencer states
    localparam int ST_BITS = 4;
    localparam logic [ST_BITS-1:0] ST_IDLE  = 4'd0;
    localparam logic [ST_BITS-1:0] ST_ADD   = 4'd1;
    localparam logic [ST_BITS-1:0] ST_SEC   = 4'd2;
    localparam logic [ST_BITS-1:0] ST_MIN   = 4'd3;
    localparam logic [ST_BITS-1:0] ST_HOUR  = 4'd4;
    localparam logic [ST_BITS-1:0] ST_MON   = 4'd5;
    localparam logic [ST_BITS-1:0] ST_YBASE = 4'd6;
    localparam logic [ST_BITS-1:0] ST_YMOD  = 4'd7;
    localparam logic [ST_BITS-1:0] ST_DAY   = 4'd8;
    localparam logic [ST_BITS-1:0] ST_DONE  = 4'd9;

    logic [COUNT_BITS-1:0]   step_count_reg;
    logic [UNIT_BITS-1:0]    step_unit_reg;

    logic [ST_BITS-1:0]      state_reg, state_next;
    logic [WORK_BITS-1:0]    sec_reg, sec_next;
    logic [WORK_BITS-1:0]    min_reg, min_next;
    logic [WORK_BITS-1:0]    hour_reg, hour_next;
    logic [WORK_BITS-1:0]    day_reg, day_next;
    logic [WORK_BITS-1:0]    mon_reg, mon_next;
    logic [WORK_BITS-1:0]    year_reg, year_next;
    logic [WORK_BITS-1:0]    ymod_reg, ymod_next;
    logic [ERR_BITS-1:0]     err_reg, err_next;
    logic [ADD_CNT_BITS-1:0] adds_left_reg, adds_left_next;

    logic                      out_valid_reg, out_valid_next;
    logic [OUT_TDATA_BITS-1:0] out_data_reg, out_data_next;

    logic                   in_fire;
    logic                   out_free;

    // Shared add/subtract unit
    logic [WORK_BITS-1:0]   alu_a;
    logic [WORK_BITS-1:0]   alu_b;
    logic                   alu_sub;
    logic [WORK_BITS:0]     alu_sum;
    logic [WORK_BITS-1:0]   alu_res;
    logic                   alu_borrow;

    logic                   leap;
    logic [WORK_BITS-1:0]   dim;
    logic [WORK_BITS-1:0]   cnt_ext;

    logic [YEAR_BITS-1:0]   year_out;
    logic [ERR_BITS-1:0]    err_out;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign cnt_ext = WORK_BITS'(step_count_reg);
    assign leap    = is_leap(ymod_reg);
    assign dim     = WORK_BITS'(month_days(mon_reg, leap));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= COUNT_BITS'(1);
            step_unit_reg  <= UNIT_SECONDS;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_STEP_COUNT: step_count_reg <= cfg_wdata[COUNT_BITS-1:0];
                REG_STEP_UNIT:  step_unit_reg  <= cfg_wdata[UNIT_BITS-1:0];
                default:        step_unit_reg  <= step_unit_reg;
            endcase
        end
    end

    // Operand selection for the shared unit
    always_comb
    begin
        alu_a   = day_reg;
        alu_b   = dim;
        alu_sub = 1'b1;
        unique case (state_reg)
            ST_ADD:
            begin
                alu_sub = 1'b0;
                alu_b   = cnt_ext;
                unique case (step_unit_reg)
                    UNIT_SECONDS: alu_a = sec_reg;
                    UNIT_MINUTES: alu_a = min_reg;
                    UNIT_HOURS:   alu_a = hour_reg;
                    UNIT_MONTHS:  alu_a = mon_reg;
                    UNIT_YEARS:   alu_a = year_reg;
                    default:      alu_a = day_reg;
                endcase
            end
            ST_SEC:
            begin
                alu_a = sec_reg;
                alu_b = SEC_PER_MIN;
            end
            ST_MIN:
            begin
                alu_a = min_reg;
                alu_b = MIN_PER_HOUR;
            end
            ST_HOUR:
            begin
                alu_a = hour_reg;
                alu_b = HOUR_PER_DAY;
            end
            ST_MON:
            begin
                alu_a = mon_reg;
                alu_b = MON_PER_YEAR;
            end
            ST_YBASE:
            begin
                alu_sub = 1'b0;
                alu_a   = year_reg;
                alu_b   = YEAR_BASE;
            end
            ST_YMOD:
            begin
                alu_a = ymod_reg;
                alu_b = LEAP_CYCLE;
            end
            default:
            begin
                alu_a = day_reg;
                alu_b = dim;
            end
        endcase
    end

    always_comb
    begin
        alu_sum    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} +
                     {{WORK_BITS{1'b0}}, alu_sub};
        alu_res    = alu_sum[WORK_BITS-1:0];
        alu_borrow = alu_sub && !alu_sum[WORK_BITS];
    end

    // Saturated year and final error code
    always_comb
    begin
        year_out = year_reg[YEAR_BITS-1:0];
        err_out  = err_reg;
        if (year_reg > YEAR_MAX)
        begin
            year_out = YEAR_MAX[YEAR_BITS-1:0];
            if (err_reg == ERR_NONE)
                err_out = ERR_OVERFLOW;
        end
    end

    // Sequencer and working registers
    always_comb
    begin
        state_next     = state_reg;
        sec_next       = sec_reg;
        min_next       = min_reg;
        hour_next      = hour_reg;
        day_next       = day_reg;
        mon_next       = mon_reg;
        year_next      = year_reg;
        ymod_next      = ymod_reg;
        err_next       = err_reg;
        adds_left_next = adds_left_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    sec_next  = WORK_BITS'(s_axis_tdata[SEC_LO +: SEC_BITS]);
                    min_next  = WORK_BITS'(s_axis_tdata[MIN_LO +: MIN_BITS]);
                    hour_next = WORK_BITS'(s_axis_tdata[HOUR_LO +: HOUR_BITS]);
                    day_next  = WORK_BITS'(s_axis_tdata[DAY_LO +: DAY_BITS]);
                    mon_next  = WORK_BITS'(s_axis_tdata[MON_LO +: MON_BITS]);
                    year_next = WORK_BITS'(s_axis_tdata[YEAR_LO +: YEAR_BITS]);
                    adds_left_next = (step_unit_reg == UNIT_WEEKS) ?
                                     ADD_CNT_BITS'(DAYS_PER_WEEK) :
                                     ADD_CNT_BITS'(1);
                    if (step_unit_reg > UNIT_YEARS)
                    begin
                        err_next   = ERR_UNIT;
                        state_next = ST_SEC;
                    end
                    else
                    begin
                        err_next   = ERR_NONE;
                        state_next = ST_ADD;
                    end
                end
            end
            ST_ADD:
            begin
                // A week step is seven passes of the count over the day
                unique case (step_unit_reg)
                    UNIT_SECONDS: sec_next  = alu_res;
                    UNIT_MINUTES: min_next  = alu_res;
                    UNIT_HOURS:   hour_next = alu_res;
                    UNIT_MONTHS:  mon_next  = alu_res;
                    UNIT_YEARS:   year_next = alu_res;
                    default:      day_next  = alu_res;
                endcase
                adds_left_next = adds_left_reg - ADD_CNT_BITS'(1);
                if (adds_left_reg == ADD_CNT_BITS'(1))
                    state_next = ST_SEC;
            end
            ST_SEC:
            begin
                if (!alu_borrow)
                begin
                    sec_next = alu_res;
                    min_next = min_reg + WORK_BITS'(1);
                end
                else
                    state_next = ST_MIN;
            end
            ST_MIN:
            begin
                if (!alu_borrow)
                begin
                    min_next  = alu_res;
                    hour_next = hour_reg + WORK_BITS'(1);
                end
                else
                    state_next = ST_HOUR;
            end
            ST_HOUR:
            begin
                if (!alu_borrow)
                begin
                    hour_next = alu_res;
                    day_next  = day_reg + WORK_BITS'(1);
                end
                else
                    state_next = ST_MON;
            end
            ST_MON:
            begin
                if (!alu_borrow)
                begin
                    mon_next  = alu_res;
                    year_next = year_reg + WORK_BITS'(1);
                end
                else
                    state_next = ST_YBASE;
            end
            ST_YBASE:
            begin
                ymod_next  = alu_res;
                state_next = ST_YMOD;
            end
            ST_YMOD:
            begin
                // Reduce the full year modulo 400 for the leap test
                if (!alu_borrow)
                    ymod_next = alu_res;
                else
                    state_next = ST_DAY;
            end
            ST_DAY:
            begin
                // Walk whole months while the day is past the month's end
                if (!alu_borrow && (alu_res != '0))
                begin
                    day_next = alu_res;
                    if (mon_reg == LAST_MONTH)
                    begin
                        mon_next  = '0;
                        year_next = year_reg + WORK_BITS'(1);
                        ymod_next = (ymod_reg == LAST_CYC_YEAR) ? '0 :
                                    ymod_reg + WORK_BITS'(1);
                    end
                    else
                        mon_next = mon_reg + WORK_BITS'(1);
                end
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_TDATA_BITS'({err_out, year_out,
                                     mon_reg[MON_BITS-1:0], day_reg[DAY_BITS-1:0],
                                     hour_reg[HOUR_BITS-1:0], min_reg[MIN_BITS-1:0],
                                     sec_reg[SEC_BITS-1:0]});
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sec_reg       <= sec_next;
        min_reg       <= min_next;
        hour_reg      <= hour_next;
        day_reg       <= day_next;
        mon_reg       <= mon_next;
        year_reg      <= year_next;
        ymod_reg      <= ymod_next;
        err_reg       <= err_next;
        adds_left_reg <= adds_left_next;
        out_data_reg  <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    // An accepted start time keeps the sequencer busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input accepted while a time was still in progress");

    // The day loop only runs on a carried month and a reduced leap year
    a_day_loop_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DAY) |-> (mon_reg < MON_PER_YEAR) && (ymod_reg < LEAP_CYCLE))
        else $error("day loop entered with an unreduced month or year");

    // A new result is only loaded when the output slot is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> $stable(out_data_reg))
        else $error("pending result overwritten");

    // Delivered results are normalized
    a_out_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[SEC_LO +: SEC_BITS] < SEC_BITS'(60)) &&
            (m_axis_tdata[MIN_LO +: MIN_BITS] < MIN_BITS'(60)) &&
            (m_axis_tdata[HOUR_LO +: HOUR_BITS] < HOUR_BITS'(24)) &&
            (m_axis_tdata[MON_LO +: MON_BITS] < MON_BITS'(12)) &&
            (m_axis_tdata[YEAR_LO + YEAR_BITS +: ERR_BITS] != 2'd3))
        else $error("result not normalized");
`endif

endmodule

// ===== test/calendar_time_advance_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// calendar_time_advance_top_tb
// Self-checking bench for the calendar time advance block. A directed set of
// start times covers the step units, count extremes, leap years, input
// fields above range, the invalid unit and year overflow. Random phases then
// reprogram the step and stream start times under several idle and stall
// patterns. A scoreboard predicts each advanced time and compares it field by
// field with the output transactions in order.
// ============================================================================
module calendar_time_advance_top_tb;

    import cta_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int RESET_CYCLES = 6;
    localparam int TOTAL_ITEMS = 550;
    localparam int SETTLE_CYCLES = 1100;
    localparam longint CYCLE_LIMIT = 4_000_000;

    // Unit code outside the defined set
    localparam logic [UNIT_BITS-1:0] UNIT_INVALID = 3'd7;

    // Start time, seconds in the lowest bits
    typedef struct packed {
        logic [YEAR_BITS-1:0] year;
        logic [MON_BITS-1:0]  month;
        logic [DAY_BITS-1:0]  day;
        logic [HOUR_BITS-1:0] hour;
        logic [MIN_BITS-1:0]  minute;
        logic [SEC_BITS-1:0]  second;
    } start_time_t;

    // Advanced time with its error code, seconds in the lowest bits
    typedef struct packed {
        logic [ERR_BITS-1:0]  err;
        logic [YEAR_BITS-1:0] year;
        logic [MON_BITS-1:0]  month;
        logic [DAY_BITS-1:0]  day;
        logic [HOUR_BITS-1:0] hour;
        logic [MIN_BITS-1:0]  minute;
        logic [SEC_BITS-1:0]  second;
    } advanced_time_t;

    typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds the step registers and the queue of advanced times
    // ------------------------------------------------------------------------
    class advance_scoreboard;
        logic [COUNT_BITS-1:0] step_count;
        logic [UNIT_BITS-1:0]  step_unit;
        advanced_time_t        pending_times[$];
        int                    mismatches;

        function new();
            step_count = COUNT_BITS'(1);
            step_unit  = UNIT_SECONDS;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_BITS-1:0] addr,
                                logic [CFG_DATA_BITS-1:0] data);
            if (addr == REG_STEP_COUNT)
                step_count = data[COUNT_BITS-1:0];
            else if (addr == REG_STEP_UNIT)
                step_unit = data[UNIT_BITS-1:0];
        endfunction

        // Gregorian month length, the year counted from 1900
        function int unsigned days_in_month(int unsigned mon, int unsigned yr);
            int unsigned full;
            bit          leap;
            full = yr + 1900;
            leap = (full % 4 == 0) && ((full % 100 != 0) || (full % 400 == 0));
            if (mon == 1)
                return leap ? 29 : 28;
            if (mon == 3 || mon == 5 || mon == 8 || mon == 10)
                return 30;
            return 31;
        endfunction

        // Adds the configured step and normalizes through all carries
        function advanced_time_t advance_time(start_time_t st);
            int unsigned sec, mins, hr, dy, mon, yr, cnt, dim, ymax;
            logic [ERR_BITS-1:0] err;
            advanced_time_t res;
            sec  = st.second;
            mins = st.minute;
            hr   = st.hour;
            dy   = st.day;
            mon  = st.month;
            yr   = st.year;
            cnt  = step_count;
            ymax = (1 << YEAR_BITS) - 1;
            err  = ERR_NONE;

            case (step_unit)
                UNIT_SECONDS: sec  += cnt;
                UNIT_MINUTES: mins += cnt;
                UNIT_HOURS:   hr   += cnt;
                UNIT_DAYS:    dy   += cnt;
                UNIT_WEEKS:   dy   += 7 * cnt;
                UNIT_MONTHS:  mon  += cnt;
                UNIT_YEARS:   yr   += cnt;
                default:      err   = ERR_UNIT;
            endcase

            mins += sec / 60;  sec  %= 60;
            hr   += mins / 60; mins %= 60;
            dy   += hr / 24;   hr   %= 24;
            yr   += mon / 12;  mon  %= 12;

            // Walk month by month; February follows the carried year
            dim = days_in_month(mon, yr);
            while (dy > dim) begin
                dy -= dim;
                mon++;
                if (mon > 11) begin
                    mon = 0;
                    yr++;
                end
                dim = days_in_month(mon, yr);
            end

            if (yr > ymax) begin
                yr = ymax;
                if (err == ERR_NONE)
                    err = ERR_OVERFLOW;
            end

            res.second = SEC_BITS'(sec);
            res.minute = MIN_BITS'(mins);
            res.hour   = HOUR_BITS'(hr);
            res.day    = DAY_BITS'(dy);
            res.month  = MON_BITS'(mon);
            res.year   = YEAR_BITS'(yr);
            res.err    = err;
            return res;
        endfunction

        function void note_start(start_time_t st);
            pending_times.push_back(advance_time(st));
        endfunction

        function int outstanding();
            return pending_times.size();
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(advanced_time_t got);
            advanced_time_t want;
            if (pending_times.size() == 0) begin
                report($sformatf("unexpected result %h", got));
            end
            else begin
                want = pending_times.pop_front();
                check_field("out_second", got.second, want.second);
                check_field("out_minute", got.minute, want.minute);
                check_field("out_hour",   got.hour,   want.hour);
                check_field("out_day",    got.day,    want.day);
                check_field("out_month",  got.month,  want.month);
                check_field("out_year",   got.year,   want.year);
                check_field("error_code", got.err,    want.err);
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test
    // ------------------------------------------------------------------------
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_ADDR_BITS-1:0]  cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    advance_scoreboard sb = new();
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     sent_items = 0;
    longint cycle_count = 0;

    calendar_time_advance_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock generation
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog on the total cycle count
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: random stall of the output channel
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitors: predict on each accepted start time, check each result
    always @(posedge clk)
    begin
        start_time_t    in_time;
        advanced_time_t out_time;
        if (rst_n && s_axis_tvalid && s_axis_tready) begin
            in_time = s_axis_tdata[IN_FIELD_BITS-1:0];
            sb.note_start(in_time);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            out_time = m_axis_tdata[OUT_FIELD_BITS-1:0];
            sb.check_result(out_time);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks; each starts and ends just after a rising edge
    // ------------------------------------------------------------------------
    task automatic set_pace(pace_t pace);
        send_idle_pct  = (pace == PACE_SEND_IDLE) ? 63 : (pace == PACE_BOTH) ? 26 : 0;
        recv_stall_pct = (pace == PACE_RECV_STALL) ? 63 : (pace == PACE_BOTH) ? 26 : 0;
    endtask

    // Writes both step registers; upper data bits of the unit write are noise
    task automatic set_step(logic [COUNT_BITS-1:0] count, logic [UNIT_BITS-1:0] unit);
        logic [CFG_DATA_BITS-1:0] unit_word;
        unit_word = CFG_DATA_BITS'($urandom);
        unit_word[UNIT_BITS-1:0] = unit;
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_STEP_COUNT;
        cfg_wdata <= CFG_DATA_BITS'(count);
        @(posedge clk);
        cfg_addr  <= REG_STEP_UNIT;
        cfg_wdata <= unit_word;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(REG_STEP_COUNT, CFG_DATA_BITS'(count));
        sb.write_reg(REG_STEP_UNIT, unit_word);
    endtask

    // Offers one start time, with a random gap first, until it is accepted
    task automatic send_time(start_time_t st);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_BITS'(st);
        do @(posedge clk); while (!s_axis_tready);
        sent_items++;
    endtask

    // Ends a burst and waits until every advanced time has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
    endtask

    // One directed start time under its own step setting
    task automatic directed(int count, logic [UNIT_BITS-1:0] unit, int sec, int mins,
                            int hr, int dy, int mon, int yr);
        start_time_t st;
        st.second = SEC_BITS'(sec);
        st.minute = MIN_BITS'(mins);
        st.hour   = HOUR_BITS'(hr);
        st.day    = DAY_BITS'(dy);
        st.month  = MON_BITS'(mon);
        st.year   = YEAR_BITS'(yr);
        set_step(COUNT_BITS'(count), unit);
        send_time(st);
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [COUNT_BITS-1:0] count;
        logic [UNIT_BITS-1:0]  unit;
        start_time_t           st;
        int                    burst;
        int                    phase;
        int                    pick;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases at full rate
        set_pace(PACE_FULL);
        directed(1, UNIT_SECONDS, 59, 59, 23, 31, 11, 1023);  // full carry chain into overflow
        directed(0, UNIT_SECONDS, 0, 0, 0, 1, 0, 0);
        directed(4095, UNIT_SECONDS, 63, 63, 31, 31, 15, 0);  // seconds, minutes, hours and month above range
        directed(4095, UNIT_MINUTES, 30, 30, 12, 15, 6, 100);
        directed(4095, UNIT_HOURS, 0, 59, 23, 31, 11, 399);
        directed(1, UNIT_DAYS, 0, 0, 0, 28, 1, 100);          // year 2000 is leap
        directed(1, UNIT_DAYS, 0, 0, 0, 28, 1, 0);            // year 1900 is not
        directed(1, UNIT_DAYS, 0, 0, 0, 28, 1, 200);          // year 2100 is not
        directed(1, UNIT_DAYS, 0, 0, 0, 28, 1, 104);
        directed(4095, UNIT_DAYS, 0, 0, 0, 31, 11, 99);       // February in the carried year
        directed(4095, UNIT_WEEKS, 0, 0, 0, 31, 11, 1000);    // weeks run past the last year
        directed(4095, UNIT_WEEKS, 0, 0, 0, 1, 0, 0);
        directed(0, UNIT_WEEKS, 12, 34, 5, 6, 7, 89);
        directed(4095, UNIT_MONTHS, 0, 0, 0, 31, 0, 0);
        directed(13, UNIT_MONTHS, 0, 0, 0, 31, 0, 50);        // lands on a short month
        directed(4095, UNIT_YEARS, 1, 2, 3, 4, 5, 6);
        directed(23, UNIT_YEARS, 0, 0, 0, 29, 1, 100);        // leap day into a common year
        directed(5, UNIT_INVALID, 10, 20, 5, 15, 3, 120);     // invalid unit
        directed(5, UNIT_INVALID, 0, 0, 0, 0, 15, 1023);      // invalid unit and overflow
        directed(0, UNIT_DAYS, 0, 0, 0, 0, 0, 10);            // day zero is kept
        directed(2, UNIT_YEARS, 0, 0, 0, 31, 15, 1021);       // month carry into overflow

        // Random phases: new step and pace each, then a burst of start times
        phase = 0;
        while (sent_items < TOTAL_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 50)
                count = COUNT_BITS'($urandom_range(15));
            else if (pick < 75)
                count = COUNT_BITS'($urandom_range(400, 16));
            else if (pick < 90)
                count = COUNT_BITS'($urandom);
            else
                count = ($urandom_range(1) != 0) ? '1 : '0;
            unit = ($urandom_range(99) < 8) ? UNIT_INVALID : UNIT_BITS'($urandom_range(6));
            set_step(count, unit);
            set_pace(pace_t'(phase % 4));

            burst = $urandom_range(20, 6);
            repeat (burst) begin
                if ($urandom_range(99) < 75) begin
                    // Well-formed time; day may exceed a short month
                    st.second = SEC_BITS'($urandom_range(59));
                    st.minute = MIN_BITS'($urandom_range(59));
                    st.hour   = HOUR_BITS'($urandom_range(23));
                    st.day    = ($urandom_range(1) != 0) ? DAY_BITS'($urandom_range(31, 28))
                                                         : DAY_BITS'($urandom_range(31, 1));
                    st.month  = MON_BITS'($urandom_range(11));
                    st.year   = ($urandom_range(3) == 0) ? YEAR_BITS'(100 * $urandom_range(10))
                                                         : YEAR_BITS'($urandom);
                end
                else begin
                    // Raw bits, fields above range included
                    st = start_time_t'(IN_FIELD_BITS'({$urandom, $urandom}));
                end
                send_time(st);
            end
            drain();
            phase++;
        end

        // Let any stray output show before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cta_pkg.sv
rtl/core/calendar_time_advance_top.sv
test/calendar_time_advance_top_tb.sv
